// ===== design/prefix_string_encoder_core_defines.svh =====
// Assertion macros shared by the checker of the prefix string encoder.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef PREFIX_STRING_ENCODER_CORE_DEFINES_SVH
`define PREFIX_STRING_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define PSE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pse_pkg.sv =====
// Types and constants of the prefix string encoder.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package pse_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = 6;
   localparam int OFF_W       = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last_of_entry;
      logic       new_page;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             last_of_run;
      logic             restart_here;
      logic [OFF_W-1:0] entry_offset;
      logic             too_long;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_out_type;

endpackage

`default_nettype wire

// ===== design/pse_channels_if.sv =====
// Valid/ready stream interfaces of the prefix string encoder.
// Depends on pse_pkg for the payload types.
`default_nettype none

interface pse_req_if ();
   logic             valid;
   logic             ready;
   pse_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pse_rsp_if ();
   logic             valid;
   logic             ready;
   pse_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/pse_front.sv =====
// Front part: accepts request beats, drops idle beats, queues the rest.
// Depends on pse_pkg and pse_req_if.
`default_nettype none

module pse_front (
   input  wire                    clock,
   input  wire                    reset,
   pse_req_if.sink                req_bus,
   output pse_pkg::queue_out_type q_out,
   input  wire                    q_ready
);

   localparam int PTR_W = $clog2(pse_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(pse_pkg::QUEUE_DEPTH + 1);

   pse_pkg::req_type item_ff [pse_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             idle_beat;
   logic             push;
   logic             pop;

   assign req_bus.ready = (count_ff != CNT_W'(pse_pkg::QUEUE_DEPTH));
   assign idle_beat = !req_bus.payload.has_byte && !req_bus.payload.last_of_entry
                      && !req_bus.payload.new_page;
   assign push = req_bus.valid && req_bus.ready && !idle_beat;
   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = item_ff[rd_ptr_ff];
   assign pop = q_out.valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= req_bus.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pse_back.sv =====
// Back part: prefix compare against the stored entry, then header and suffix emission.
// Depends on pse_pkg and pse_rsp_if; holds the entry memory and the output register.
`default_nettype none

module pse_back #(
   parameter int MAX_ENTRY_BYTES = 32
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire pse_pkg::queue_out_type q_in,
   output logic                        q_ready,
   pse_rsp_if.source                   rsp_bus,
   input  wire                         csr_we,
   input  wire  [7:0]                  csr_wdata
);

   localparam int LW = pse_pkg::LEN_W;
   localparam int AW = pse_pkg::ADDR_W;
   localparam int OW = pse_pkg::OFF_W;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_ENTRY_BYTES);

   typedef enum logic [3:0] {
      ST_TAKE = 4'b0001,
      ST_HDR0 = 4'b0010,
      ST_HDR1 = 4'b0100,
      ST_BODY = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [LW-1:0]     len_ff, len_in;
   logic [LW-1:0]     prev_ff, prev_in;
   logic [LW-1:0]     shc_ff, shc_in;
   logic              match_ff, match_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        ipos_ff, ipos_in;
   logic [OW-1:0]     off_ff, off_in;
   logic [7:0]        interval_ff, interval_in;
   logic [LW-1:0]     em_shared_ff, em_shared_in;
   logic [LW-1:0]     em_unshared_ff, em_unshared_in;
   logic [LW-1:0]     em_end_ff, em_end_in;
   logic              em_restart_ff, em_restart_in;
   logic [OW-1:0]     em_start_ff, em_start_in;
   logic              em_ovf_ff, em_ovf_in;
   logic [LW-1:0]     ptr_ff, ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   pse_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic [7:0]        store_mem [pse_pkg::STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;

   logic              out_free;

   assign q_ready         = (state_ff == ST_TAKE);
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;
   assign interval_in     = csr_we ? csr_wdata : interval_ff;

   always_comb begin
      logic          page;
      logic [LW-1:0] len_b, shc_b, prev_b, len_n, shc_n, shared, unshared;
      logic          match_b, ovf_b, match_n, ovf_n, hit, restart;
      logic [7:0]    ipos_b;
      logic [OW-1:0] off_b;
      logic [8:0]    ipos_inc;

      page     = q_in.item.new_page;
      len_b    = page ? '0 : len_ff;
      shc_b    = page ? '0 : shc_ff;
      prev_b   = page ? '0 : prev_ff;
      match_b  = page ? 1'b1 : match_ff;
      ovf_b    = page ? 1'b0 : ovf_ff;
      ipos_b   = page ? '0 : ipos_ff;
      off_b    = page ? '0 : off_ff;
      len_n    = len_b;
      shc_n    = shc_b;
      match_n  = match_b;
      ovf_n    = ovf_b;
      hit      = 1'b0;
      restart  = (ipos_b == '0);
      shared   = '0;
      unshared = '0;
      ipos_inc = {1'b0, ipos_b} + 9'd1;

      state_in       = state_ff;
      len_in         = len_ff;
      prev_in        = prev_ff;
      shc_in         = shc_ff;
      match_in       = match_ff;
      ovf_in         = ovf_ff;
      ipos_in        = ipos_ff;
      off_in         = off_ff;
      em_shared_in   = em_shared_ff;
      em_unshared_in = em_unshared_ff;
      em_end_in      = em_end_ff;
      em_restart_in  = em_restart_ff;
      em_start_in    = em_start_ff;
      em_ovf_in      = em_ovf_ff;
      ptr_in         = ptr_ff;
      mem_we         = 1'b0;
      mem_waddr      = len_b[AW-1:0];
      mem_raddr      = len_ff[AW-1:0];
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in    = rsp_data_ff;

      case (state_ff)
         ST_TAKE: begin
            if (q_in.valid) begin
               if (q_in.item.has_byte) begin
                  if (len_b < MAX_LEN) begin
                     mem_we  = 1'b1;
                     hit     = match_b && (len_b < prev_b)
                               && (rd_data_ff == q_in.item.data_byte);
                     shc_n   = hit ? shc_b + LW'(1) : shc_b;
                     match_n = hit;
                     len_n   = len_b + LW'(1);
                  end else begin
                     ovf_n = 1'b1;
                  end
               end
               if (q_in.item.last_of_entry) begin
                  shared         = restart ? '0 : shc_n;
                  unshared       = len_n - shared;
                  em_shared_in   = shared;
                  em_unshared_in = unshared;
                  em_end_in      = len_n;
                  em_restart_in  = restart;
                  em_start_in    = off_b;
                  em_ovf_in      = ovf_n;
                  ptr_in         = shared;
                  off_in         = off_b + OW'(unshared) + OW'(2);
                  ipos_in        = (ipos_inc >= {1'b0, interval_ff}) ? '0 : ipos_inc[7:0];
                  prev_in        = len_n;
                  len_in         = '0;
                  shc_in         = '0;
                  match_in       = 1'b1;
                  ovf_in         = 1'b0;
                  mem_raddr      = shared[AW-1:0];
                  state_in       = ST_HDR0;
               end else begin
                  len_in    = len_n;
                  shc_in    = shc_n;
                  match_in  = match_n;
                  ovf_in    = ovf_n;
                  prev_in   = prev_b;
                  ipos_in   = ipos_b;
                  off_in    = off_b;
                  mem_raddr = len_n[AW-1:0];
               end
            end
         end
         ST_HDR0: begin
            mem_raddr = ptr_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: 8'(em_shared_ff), last_of_run: 1'b0,
                                restart_here: em_restart_ff, entry_offset: em_start_ff,
                                too_long: em_ovf_ff};
               state_in     = ST_HDR1;
            end
         end
         ST_HDR1: begin
            mem_raddr = ptr_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: 8'(em_unshared_ff),
                                last_of_run: (em_unshared_ff == '0),
                                restart_here: em_restart_ff, entry_offset: em_start_ff,
                                too_long: em_ovf_ff};
               if (em_unshared_ff == '0) begin
                  mem_raddr = len_ff[AW-1:0];
                  state_in  = ST_TAKE;
               end else begin
                  state_in  = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            mem_raddr = ptr_ff[AW-1:0];
            if (out_free) begin
               ptr_in       = ptr_ff + LW'(1);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: rd_data_ff, last_of_run: (ptr_in == em_end_ff),
                                restart_here: em_restart_ff, entry_offset: em_start_ff,
                                too_long: em_ovf_ff};
               if (ptr_in == em_end_ff) begin
                  mem_raddr = len_ff[AW-1:0];
                  state_in  = ST_TAKE;
               end else begin
                  mem_raddr = ptr_in[AW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   // write-first read: a byte written this cycle is seen at once
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= q_in.item.data_byte;
      end
      if (mem_we && (mem_waddr == mem_raddr)) begin
         rd_data_ff <= q_in.item.data_byte;
      end else begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      em_shared_ff   <= em_shared_in;
      em_unshared_ff <= em_unshared_in;
      em_end_ff      <= em_end_in;
      em_restart_ff  <= em_restart_in;
      em_start_ff    <= em_start_in;
      em_ovf_ff      <= em_ovf_in;
      ptr_ff         <= ptr_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TAKE;
         len_ff       <= '0;
         prev_ff      <= '0;
         shc_ff       <= '0;
         match_ff     <= 1'b1;
         ovf_ff       <= 1'b0;
         ipos_ff      <= '0;
         off_ff       <= '0;
         interval_ff  <= 8'd16;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         prev_ff      <= prev_in;
         shc_ff       <= shc_in;
         match_ff     <= match_in;
         ovf_ff       <= ovf_in;
         ipos_ff      <= ipos_in;
         off_ff       <= off_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/prefix_string_encoder_core.sv =====
// Prefix (front-coding) string encoder with restart points.
// Each request beat carries at most one entry byte; last_of_entry set ends the entry.
// At each entry end the rsp channel gives shared length, unshared length, then the
// unshared suffix bytes, each tagged with restart_here, entry_offset and too_long.
// csr_we/csr_wdata write restart_interval (reset value 16). The user must write it
// only while the block is idle; the block itself does not enforce this. Throughput:
// one request beat per cycle while an entry is collected; an entry end holds the
// back part while it gives the two header beats and the suffix beats, one rsp beat
// per cycle when the receiver is ready; a two-beat queue takes up to two more req
// beats then. First rsp beat path: queue register, compare stage, output register.
// Beats with no byte, no entry end and no page start are dropped at the front.
// Reset clears state, counters and flags; the entry memory needs no clearing pass.
// When the receiver stalls, the output register holds its beat, the back part waits,
// and req_bus.ready drops once the queue is full.
// Depends on pse_pkg, pse_req_if, pse_rsp_if, pse_front and pse_back.
`default_nettype none

module prefix_string_encoder_core #(
   parameter int MAX_ENTRY_BYTES = 32
) (
   input  wire        clock,
   input  wire        reset,
   pse_req_if.sink    req_bus,
   pse_rsp_if.source  rsp_bus,
   input  wire        csr_we,
   input  wire  [7:0] csr_wdata
);

   pse_pkg::queue_out_type q_out;
   logic                   q_ready;

   pse_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_out   (q_out),
      .q_ready (q_ready)
   );

   pse_back #(
      .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_out),
      .q_ready   (q_ready),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== design/pse_checker.sv =====
// Port-level checker for prefix_string_encoder_core, bound to the top level.
// Depends on pse_pkg and prefix_string_encoder_core_defines.svh.
`default_nettype none
`include "prefix_string_encoder_core_defines.svh"

module pse_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input wire pse_pkg::rsp_type rsp_payload
);

   logic                     mid_beat;
   logic                     stalled;
   logic [pse_pkg::OFF_W+1:0] tags;

   assign mid_beat = rsp_valid && rsp_ready && !rsp_payload.last_of_run;
   assign stalled  = rsp_valid && !rsp_ready;
   assign tags     = {rsp_payload.entry_offset, rsp_payload.restart_here, rsp_payload.too_long};

   `PSE_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid && $stable(rsp_payload), "stalled beat changed")
   `PSE_ASSERT_SAME(a_reset_quiet, $past(reset), !rsp_valid, "rsp valid right after reset")
   `PSE_ASSERT_NEXT(a_run_gapless, mid_beat, rsp_valid, "gap inside an encoded entry")
   `PSE_ASSERT_NEXT(a_run_tags, mid_beat, $stable(tags), "entry tags changed inside a run")

endmodule

bind prefix_string_encoder_core pse_checker u_pse_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

`default_nettype wire
